>>> hdl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and command codes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    // command kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_CREATE  = 3'd1;
    localparam logic [2:0] KIND_RESUME  = 3'd2;
    localparam logic [2:0] KIND_SUSPEND = 3'd3;
    localparam logic [2:0] KIND_DELETE  = 3'd4;

    // input word
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [7:0]  delay_ticks;
    } cmd_t;

    // result word
    typedef struct packed {
        logic       fired;
        logic [2:0] run_slot;
        logic       last;
    } result_t;

    // flag update for one slot
    typedef struct packed {
        logic set_used;
        logic clr_used;
        logic set_susp;
        logic clr_susp;
    } flag_cmd_t;

endpackage

>>> hdl/ptts_alu.sv
// ----------------------------------------------------------------------------
// ptts_alu
// Shared countdown unit: fire test, decrement or reload from period.
// ----------------------------------------------------------------------------
module ptts_alu #(
    parameter int COUNT_BITS = 16
) (
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] period,
    output logic                  fire,
    output logic [COUNT_BITS-1:0] next_count
);

    // zero countdown fires and reloads to period - 1, zero period acts as one
    always_comb
    begin
        fire = (count == '0);
        if (fire)
        begin
            next_count = (period == '0) ? '0 : period - COUNT_BITS'(1);
        end
        else
        begin
            next_count = count - COUNT_BITS'(1);
        end
    end

endmodule

>>> hdl/ptts_table.sv
// ----------------------------------------------------------------------------
// ptts_table
// Task slot table: flag registers plus a period/countdown memory with a
// registered read port.
// ----------------------------------------------------------------------------
module ptts_table #(
    parameter int TASK_SLOTS = 8,
    parameter int COUNT_BITS = 16,
    parameter int SLOT_BITS  = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptts_pkg::flag_cmd_t    flag_cmd,
    input  logic [SLOT_BITS-1:0]   flag_addr,
    input  logic                   wr_en,
    input  logic [SLOT_BITS-1:0]   wr_addr,
    input  logic [COUNT_BITS-1:0]  wr_period,
    input  logic [COUNT_BITS-1:0]  wr_count,
    input  logic [SLOT_BITS-1:0]   rd_addr,
    output logic [COUNT_BITS-1:0]  rd_period,
    output logic [COUNT_BITS-1:0]  rd_count,
    output logic [TASK_SLOTS-1:0]  used,
    output logic [TASK_SLOTS-1:0]  suspended
);

    logic [TASK_SLOTS-1:0]   used_reg;
    logic [TASK_SLOTS-1:0]   susp_reg;
    logic [2*COUNT_BITS-1:0] mem [TASK_SLOTS];
    logic [2*COUNT_BITS-1:0] rd_data_reg;

    // occupied and suspended flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            susp_reg <= '0;
        end
        else
        begin
            if (flag_cmd.set_used)
            begin
                used_reg[flag_addr] <= 1'b1;
            end
            else if (flag_cmd.clr_used)
            begin
                used_reg[flag_addr] <= 1'b0;
            end
            if (flag_cmd.set_susp)
            begin
                susp_reg[flag_addr] <= 1'b1;
            end
            else if (flag_cmd.clr_susp)
            begin
                susp_reg[flag_addr] <= 1'b0;
            end
        end
    end

    // period and countdown memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_period, wr_count};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_period = rd_data_reg[2*COUNT_BITS-1:COUNT_BITS];
    assign rd_count  = rd_data_reg[COUNT_BITS-1:0];
    assign used      = used_reg;
    assign suspended = susp_reg;

endmodule

>>> hdl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Table of prioritized periodic task slots; each tick word scans the table
// and reports the tasks that are due.
// ----------------------------------------------------------------------------
// A create, resume, suspend or delete word is taken straight from idle and busy
// stays low. A tick word holds busy high while the table memory is read one
// slot per cycle and a single countdown unit updates each used, unsuspended
// slot as its data returns. Each due task produces one result word, in slot
// order, shown for exactly one cycle with result_valid; the receiver cannot
// stall, so it must take every word as it appears. The final word of a tick
// has last set, and a tick with no due task gives one word with fired clear.
// The final word appears in the cycle busy drops.
module periodic_task_tick_scheduler #(
    parameter int TASK_SLOTS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptts_pkg::cmd_t     cmd,
    output logic               result_valid,
    output ptts_pkg::result_t  result
);

    localparam int SLOT_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(TASK_SLOTS + 1);
    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    scan_reg, scan_next;
    logic [SLOT_BITS-1:0]   eval_idx_reg, eval_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [2:0]             pend_slot_reg, pend_slot_next;
    logic                   result_valid_reg, result_valid_next;
    ptts_pkg::result_t      result_reg, result_next;

    ptts_pkg::flag_cmd_t    flag_cmd;
    logic [SLOT_BITS-1:0]   slot_idx;
    logic                   slot_ok;
    logic                   accept;
    logic                   wr_en;
    logic [SLOT_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0]  wr_period;
    logic [COUNT_BITS-1:0]  wr_count;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [COUNT_BITS-1:0]  rd_period;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [TASK_SLOTS-1:0]  used;
    logic [TASK_SLOTS-1:0]  suspended;
    logic [COUNT_BITS-1:0]  period_sat;
    logic                   eval_active;
    logic                   live;
    logic                   fire;
    logic [COUNT_BITS-1:0]  next_count;

    assign accept   = start && (state_reg == ST_IDLE);
    assign slot_idx = SLOT_BITS'(cmd.slot);
    assign slot_ok  = (32'(cmd.slot) < 32'(TASK_SLOTS));

    // saturate the period to the countdown width
    assign period_sat = (33'(cmd.period) > CNT_MAX_W) ? '1 : COUNT_BITS'(cmd.period);

    // scan read address and the slot being evaluated
    assign rd_addr     = scan_reg[SLOT_BITS-1:0];
    assign eval_active = (state_reg == ST_SCAN) && (scan_reg != '0);
    assign live        = used[eval_idx_reg] && !suspended[eval_idx_reg];

    // command decode into flag updates
    always_comb
    begin
        flag_cmd = '0;
        if (accept && slot_ok)
        begin
            unique case (cmd.kind)
                ptts_pkg::KIND_CREATE:
                begin
                    flag_cmd.set_used = !used[slot_idx];
                    flag_cmd.clr_susp = !used[slot_idx];
                end
                ptts_pkg::KIND_RESUME:  flag_cmd.clr_susp = 1'b1;
                ptts_pkg::KIND_SUSPEND: flag_cmd.set_susp = 1'b1;
                ptts_pkg::KIND_DELETE:  flag_cmd.clr_used = 1'b1;
                default:                flag_cmd = '0;
            endcase
        end
    end

    // table write: create in idle, countdown update during scan
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            wr_en     = eval_active && live;
            wr_addr   = eval_idx_reg;
            wr_period = rd_period;
            wr_count  = next_count;
        end
        else
        begin
            wr_en     = accept && slot_ok && (cmd.kind == ptts_pkg::KIND_CREATE)
                        && !used[slot_idx];
            wr_addr   = slot_idx;
            wr_period = period_sat;
            wr_count  = COUNT_BITS'(cmd.delay_ticks);
        end
    end

    ptts_table #(
        .TASK_SLOTS (TASK_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .SLOT_BITS  (SLOT_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .flag_cmd  (flag_cmd),
        .flag_addr (slot_idx),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_period (wr_period),
        .wr_count  (wr_count),
        .rd_addr   (rd_addr),
        .rd_period (rd_period),
        .rd_count  (rd_count),
        .used      (used),
        .suspended (suspended)
    );

    ptts_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .count      (rd_count),
        .period     (rd_period),
        .fire       (fire),
        .next_count (next_count)
    );

    // sequencer; a due task is held back one find so last can be marked
    always_comb
    begin
        state_next        = state_reg;
        scan_next         = scan_reg;
        eval_idx_next     = eval_idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.kind == ptts_pkg::KIND_TICK))
                begin
                    state_next      = ST_SCAN;
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                scan_next     = scan_reg + CNT_BITS'(1);
                eval_idx_next = rd_addr;
                if (eval_active && live && fire)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next    = 1'b1;
                        result_next.fired    = 1'b1;
                        result_next.run_slot = pend_slot_reg;
                        result_next.last     = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = 3'(eval_idx_reg);
                end
                if (scan_reg == CNT_BITS'(TASK_SLOTS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                result_valid_next    = 1'b1;
                result_next.fired    = pend_valid_reg;
                result_next.run_slot = pend_valid_reg ? pend_slot_reg : 3'd0;
                result_next.last     = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_reg         <= scan_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg  <= eval_idx_next;
        pend_slot_reg <= pend_slot_next;
        result_reg    <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hdl/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks for the periodic task tick scheduler, bound to the top.
// ----------------------------------------------------------------------------
module ptts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input ptts_pkg::cmd_t     cmd,
    input logic               result_valid,
    input ptts_pkg::result_t  result
);

    // a tick word always starts a scan
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.kind == ptts_pkg::KIND_TICK) |=> busy)
        else $error("tick word did not raise busy");

    // the final word of a tick appears as busy drops
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && result.last)
        else $error("busy dropped without a final word");

    // a final word is only shown once the scan is over
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("final word while still scanning");

    // an empty tick word is the only word of its tick and names slot zero
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fired |-> result.last && (result.run_slot == 3'd0))
        else $error("malformed empty tick word");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);
